// ----- sv/lcdseq_pkg.sv -----
package lcdseq_pkg;

   // Display geometry and decimal print depth
   localparam int COLUMNS    = 16;
   localparam int MAX_DIGITS = 10;

   localparam int DIGIT_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

   // Request kinds
   localparam logic [2:0] KIND_INIT    = 3'd0;
   localparam logic [2:0] KIND_COMMAND = 3'd1;
   localparam logic [2:0] KIND_CHAR    = 3'd2;
   localparam logic [2:0] KIND_CLEAR   = 3'd3;
   localparam logic [2:0] KIND_CURSOR  = 3'd4;
   localparam logic [2:0] KIND_PRINT   = 3'd5;

   // Cursor lines that move the cursor
   localparam logic [1:0] LINE_ONE = 2'd1;
   localparam logic [1:0] LINE_TWO = 2'd2;

   // Controller command bytes
   localparam logic [7:0] CMD_WAKE       = 8'h30;
   localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
   localparam logic [7:0] CMD_CURSOR_OFF = 8'h10;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_SHIFT_R    = 8'h14;
   localparam logic [7:0] CMD_LINE_TWO   = 8'hC0;
   localparam logic [7:0] ASCII_ZERO     = 8'h30;

   // Phase hold times, nominal microseconds
   localparam logic [10:0] HOLD_SETUP    = 11'd6;
   localparam logic [10:0] HOLD_STROBE   = 11'd6;
   localparam logic [10:0] HOLD_RELEASE  = 11'd40;
   localparam logic [10:0] HOLD_POWER_UP = 11'd1500;
   localparam logic [10:0] HOLD_LONG     = 11'd1600;
   localparam logic [10:0] EXTRA_WAKE1   = 11'd500;
   localparam logic [10:0] EXTRA_WAKE2   = 11'd16;
   localparam logic [10:0] EXTRA_NONE    = 11'd0;

   // Divide by ten through a reciprocal multiply
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [2:0] INIT_LAST_STEP = 3'd7;

   // One bus operation handed from the sequencer to the phase writer.
   // single: one phase of its own with hold as given; otherwise a full write
   // whose release phase lasts HOLD_RELEASE plus hold.
   typedef struct packed {
      logic        single;
      logic        use_held;
      logic [7:0]  data;
      logic        rs;
      logic [10:0] hold;
      logic        last;
   } bus_op_type;

   function automatic bus_op_type make_write(input logic [7:0] data, input logic rs,
                                             input logic [10:0] extra, input logic last);
      bus_op_type op;
      op          = '0;
      op.data     = data;
      op.rs       = rs;
      op.hold     = extra;
      op.last     = last;
      return op;
   endfunction

   // Power-up sequence: one wait, then seven command writes
   function automatic bus_op_type init_op(input logic [2:0] step);
      bus_op_type op;
      op = '0;
      unique case (step)
         3'd0: begin
            op.single = 1'b1;
            op.hold   = HOLD_POWER_UP;
         end
         3'd1: op = make_write(CMD_WAKE, 1'b0, EXTRA_WAKE1, 1'b0);
         3'd2: op = make_write(CMD_WAKE, 1'b0, EXTRA_WAKE2, 1'b0);
         3'd3: op = make_write(CMD_WAKE, 1'b0, EXTRA_WAKE2, 1'b0);
         3'd4: op = make_write(CMD_FUNC_SET, 1'b0, EXTRA_NONE, 1'b0);
         3'd5: op = make_write(CMD_CURSOR_OFF, 1'b0, EXTRA_NONE, 1'b0);
         3'd6: op = make_write(CMD_DISPLAY_ON, 1'b0, EXTRA_NONE, 1'b0);
         3'd7: op = make_write(CMD_ENTRY_MODE, 1'b0, EXTRA_NONE, 1'b1);
      endcase
      return op;
   endfunction

endpackage

// ----- sv/lcdseq_div10.sv -----
module lcdseq_div10
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] operand,
   output logic        done,
   output logic [31:0] quotient,
   output logic [3:0]  digit
);

   logic        stage_ff, stage_in;
   logic        done_ff, done_in;
   logic [31:0] val_ff, val_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] quot_ff, quot_in;
   logic [3:0]  digit_ff, digit_in;
   logic [31:0] q_calc;
   logic [31:0] tens;
   logic [31:0] diff;

   assign stage_in = start;
   assign done_in  = stage_ff;
   assign val_in   = start ? operand : val_ff;
   assign prod_in  = start ? ({32'd0, operand} * {32'd0, RECIP_10}) : prod_ff;

   // Quotient from the reciprocal product, remainder by shift-add back-multiply
   assign q_calc   = 32'(prod_ff >> RECIP_SHIFT);
   assign tens     = (q_calc << 3) + (q_calc << 1);
   assign diff     = val_ff - tens;
   assign quot_in  = stage_ff ? q_calc : quot_ff;
   assign digit_in = stage_ff ? diff[3:0] : digit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      prod_ff  <= prod_in;
      quot_ff  <= quot_in;
      digit_ff <= digit_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
   assign digit    = digit_ff;

endmodule

// ----- sv/lcdseq_writer.sv -----
module lcdseq_writer
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  bus_op_type  cmd_op,
   output logic        cmd_ready,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [7:0]  rsp_data_bus,
   output logic        rsp_reg_select,
   output logic        rsp_enable,
   output logic [10:0] rsp_hold_time,
   output logic        rsp_last
);

   typedef enum logic [2:0] {
      STEP_SETUP   = 3'b001,
      STEP_STROBE  = 3'b010,
      STEP_RELEASE = 3'b100
   } write_step_type;

   logic           busy_ff, busy_in;
   bus_op_type     op_ff, op_in;
   write_step_type step_ff, step_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     held_data_ff, held_data_in;
   logic           held_select_ff, held_select_in;
   logic [7:0]     out_data_ff, out_data_in;
   logic           out_rs_ff, out_rs_in;
   logic           out_e_ff, out_e_in;
   logic [10:0]    out_hold_ff, out_hold_in;
   logic           out_last_ff, out_last_in;

   logic           load;
   logic           fin;
   logic [7:0]     ph_data;
   logic           ph_rs;
   logic           ph_e;
   logic [10:0]    ph_hold;

   assign cmd_ready = !busy_ff;
   assign load      = busy_ff && (!out_valid_ff || !rsp_stall);

   always_comb begin
      ph_data = op_ff.use_held ? held_data_ff : op_ff.data;
      ph_rs   = op_ff.use_held ? held_select_ff : op_ff.rs;
      ph_e    = 1'b0;
      ph_hold = op_ff.hold;
      fin     = 1'b1;
      if (!op_ff.single) begin
         unique case (step_ff)
            STEP_SETUP: begin
               ph_hold = HOLD_SETUP;
               fin     = 1'b0;
            end
            STEP_STROBE: begin
               ph_e    = 1'b1;
               ph_hold = HOLD_STROBE;
               fin     = 1'b0;
            end
            default: begin
               ph_hold = HOLD_RELEASE + op_ff.hold;
            end
         endcase
      end
   end

   always_comb begin
      busy_in        = busy_ff;
      op_in          = op_ff;
      step_in        = step_ff;
      held_data_in   = held_data_ff;
      held_select_in = held_select_ff;
      out_data_in    = out_data_ff;
      out_rs_in      = out_rs_ff;
      out_e_in       = out_e_ff;
      out_hold_in    = out_hold_ff;
      out_last_in    = out_last_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      if (cmd_valid && cmd_ready) begin
         busy_in = 1'b1;
         op_in   = cmd_op;
         step_in = STEP_SETUP;
      end
      if (load) begin
         out_valid_in   = 1'b1;
         out_data_in    = ph_data;
         out_rs_in      = ph_rs;
         out_e_in       = ph_e;
         out_hold_in    = ph_hold;
         out_last_in    = fin && op_ff.last;
         held_data_in   = ph_data;
         held_select_in = ph_rs;
         if (fin) begin
            busy_in = 1'b0;
         end else begin
            step_in = (step_ff == STEP_SETUP) ? STEP_STROBE : STEP_RELEASE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
         held_data_ff   <= 8'd0;
         held_select_ff <= 1'b0;
         step_ff        <= STEP_SETUP;
      end else begin
         busy_ff        <= busy_in;
         out_valid_ff   <= out_valid_in;
         held_data_ff   <= held_data_in;
         held_select_ff <= held_select_in;
         step_ff        <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      out_data_ff <= out_data_in;
      out_rs_ff   <= out_rs_in;
      out_e_ff    <= out_e_in;
      out_hold_ff <= out_hold_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_data_bus   = out_data_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_enable     = out_e_ff;
   assign rsp_hold_time  = out_hold_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ----- sv/char_lcd_bus_sequencer.sv -----
// Character LCD bus sequencer for an 8-bit parallel character panel. Each request
// transaction (init, command, character, clear, set cursor, print decimal)
// turns into a run of pin-phase transactions on the rsp_ channel, each giving
// the data pins, RS, E and a hold time in nominal microseconds; the final
// phase of a run carries rsp_last. A request is taken only while the
// sequencer is idle, and kinds 6 and 7 are dropped with no output. Each bus
// write is three phases: the phase writer loads its phase register for each
// phase, then takes the next operation. A line-1 cursor move is a home write
// and one right shift per column, and a print decimal first runs every digit
// through the shared divide-by-ten unit (a 32x32 reciprocal multiply followed
// by a shift-add back-multiply) before it writes them. Stalls on the rsp_
// channel hold the run back.
module char_lcd_bus_sequencer
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_value,
   input  logic [1:0]  req_line,
   input  logic [3:0]  req_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_bus,
   output logic        rsp_reg_select,
   output logic        rsp_enable,
   output logic [10:0] rsp_hold_time,
   output logic        rsp_last
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_INIT   = 6'b000010,
      ST_SINGLE = 6'b000100,
      ST_CURSOR = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_PRINT  = 6'b100000
   } seq_state_type;

   seq_state_type          state_ff, state_in;
   logic [2:0]             kind_ff, kind_in;
   logic [7:0]             byte_ff, byte_in;
   logic [1:0]             line_ff, line_in;
   logic [3:0]             col_ff, col_in;
   logic [3:0]             step_ff, step_in;
   logic [31:0]            rem_ff, rem_in;
   logic [DIGIT_CNT_W-1:0] count_ff, count_in;
   logic                   pending_ff, pending_in;
   logic [3:0]             digit_store [MAX_DIGITS];

   logic                   cmd_valid;
   logic                   cmd_ready;
   bus_op_type             cmd_op;
   logic                   div_start;
   logic                   div_done;
   logic [31:0]            div_quot;
   logic [3:0]             div_digit;
   logic [3:0]             col_sat;
   logic                   cursor_fin;
   logic [DIGIT_CNT_W-1:0] count_next;
   logic [DIGIT_CNT_W-1:0] count_prev;
   logic [3:0]             print_digit;

   // Accept only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // Clamp the column to the display width
   assign col_sat = (int'(req_col) > COLUMNS - 1) ? 4'(COLUMNS - 1) : req_col;

   assign cursor_fin  = (step_ff == col_ff);
   assign count_next  = count_ff + DIGIT_CNT_W'(1);
   assign count_prev  = count_ff - DIGIT_CNT_W'(1);
   assign print_digit = digit_store[count_prev[DIGIT_IDX_W-1:0]];

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      byte_in    = byte_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      cmd_valid  = 1'b0;
      cmd_op     = '0;
      div_start  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               byte_in  = req_value[7:0];
               line_in  = req_line;
               col_in   = col_sat;
               step_in  = '0;
               count_in = '0;
               rem_in   = req_value;
               unique case (req_kind)
                  KIND_INIT: state_in = ST_INIT;
                  KIND_COMMAND, KIND_CHAR, KIND_CLEAR: state_in = ST_SINGLE;
                  KIND_CURSOR: state_in = (req_line == LINE_ONE) ? ST_CURSOR : ST_SINGLE;
                  KIND_PRINT: state_in = ST_DIV;
                  default: state_in = ST_IDLE;  // unknown kind: drop
               endcase
            end
         end

         ST_INIT: begin
            cmd_valid = 1'b1;
            cmd_op    = init_op(step_ff[2:0]);
            if (cmd_ready) begin
               step_in = step_ff + 4'd1;
               if (step_ff[2:0] == INIT_LAST_STEP) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SINGLE: begin
            cmd_valid = 1'b1;
            unique case (kind_ff)
               KIND_COMMAND: cmd_op = make_write(byte_ff, 1'b0, EXTRA_NONE, 1'b1);
               KIND_CHAR:    cmd_op = make_write(byte_ff, 1'b1, EXTRA_NONE, 1'b1);
               KIND_CLEAR:   cmd_op = make_write(CMD_CLEAR, 1'b0, HOLD_LONG, 1'b1);
               default: begin
                  if (line_ff == LINE_TWO) begin
                     cmd_op = make_write(CMD_LINE_TWO + {4'd0, col_ff}, 1'b0,
                                         HOLD_LONG, 1'b1);
                  end else begin
                     // Any other line: just wait, pins left as they were
                     cmd_op          = '0;
                     cmd_op.single   = 1'b1;
                     cmd_op.use_held = 1'b1;
                     cmd_op.hold     = HOLD_LONG;
                     cmd_op.last     = 1'b1;
                  end
               end
            endcase
            if (cmd_ready) begin
               state_in = ST_IDLE;
            end
         end

         ST_CURSOR: begin
            // Home, then one right shift per column; long wait on the final write
            cmd_valid = 1'b1;
            cmd_op    = make_write((step_ff == 4'd0) ? CMD_HOME : CMD_SHIFT_R, 1'b0,
                                   cursor_fin ? HOLD_LONG : EXTRA_NONE, cursor_fin);
            if (cmd_ready) begin
               step_in = step_ff + 4'd1;
               if (cursor_fin) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_DIV: begin
            // Peel off the least significant digit each pass
            div_start = !pending_ff;
            if (!pending_ff) begin
               pending_in = 1'b1;
            end
            if (div_done) begin
               pending_in = 1'b0;
               rem_in     = div_quot;
               count_in   = count_next;
               if (div_quot == 32'd0 || count_next == DIGIT_CNT_W'(MAX_DIGITS)) begin
                  state_in = ST_PRINT;
               end
            end
         end

         ST_PRINT: begin
            // Most significant digit first
            cmd_valid = 1'b1;
            cmd_op    = make_write(ASCII_ZERO + {4'd0, print_digit}, 1'b1, EXTRA_NONE,
                                   count_ff == DIGIT_CNT_W'(1));
            if (cmd_ready) begin
               count_in = count_prev;
               if (count_ff == DIGIT_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      line_ff <= line_in;
      col_ff  <= col_in;
      rem_ff  <= rem_in;
   end

   // Digit store: written once per division pass
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && div_done) begin
         digit_store[count_ff[DIGIT_IDX_W-1:0]] <= div_digit;
      end
   end

   lcdseq_div10 u_div10 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .operand  (rem_ff),
      .done     (div_done),
      .quotient (div_quot),
      .digit    (div_digit)
   );

   lcdseq_writer u_writer (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_op         (cmd_op),
      .cmd_ready      (cmd_ready),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_data_bus   (rsp_data_bus),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_hold_time  (rsp_hold_time),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- sim/char_lcd_bus_sequencer_tb.sv -----
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_tb;
   import lcdseq_pkg::*;

   // Watchdog: cycles with no transaction on either channel before giving up.
   // The longest quiet stretch in a correct run is the receiver hold-off below.
   localparam int IDLE_LIMIT   = 3000;
   // Quiet cycles after the last expected phase, to catch stray output
   localparam int SETTLE_TICKS = 64;
   // Length of the deliberate receiver hold-off that fills the block up
   localparam int HOLD_OFF     = 300;
   localparam int RANDOM_ITEMS = 180;

   // Kinds the block must drop without a phase or a change of pin state
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;
   // Cursor lines that only wait with the pins held
   localparam logic [1:0] LINE_IDLE_LO  = 2'd0;
   localparam logic [1:0] LINE_IDLE_HI  = 2'd3;

   typedef struct packed {
      logic [7:0]  data;
      logic        rs;
      logic        e;
      logic [10:0] hold;
      logic        last;
   } lcd_phase_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic [31:0] req_value;
   logic [1:0]  req_line;
   logic [3:0]  req_col;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_data_bus;
   logic        rsp_reg_select;
   logic        rsp_enable;
   logic [10:0] rsp_hold_time;
   logic        rsp_last;

   // Bus phases still owed by the block, oldest first
   lcd_phase_type lcd_phases_due[$];
   // Newest phase of the run being predicted; its last flag is settled on close
   lcd_phase_type run_tail;
   bit          run_open;
   // Pin levels left behind by the last predicted phase
   logic [7:0]  pin_data;
   logic        pin_rs;

   int          fault_count   = 0;
   int          idle_ticks    = 0;
   int          sink_hold_req = 0;
   bit          sender_calm   = 1'b0;
   bit          sink_calm     = 1'b0;

   char_lcd_bus_sequencer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_line       (req_line),
      .req_col        (req_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_bus   (rsp_data_bus),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_hold_time  (rsp_hold_time),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Bus phase predictor
   // ------------------------------------------------------------------

   // Queue the previous phase and keep this one back until the run's end is known
   function automatic void emit_phase(input logic [7:0] data, input logic rs,
                                      input logic e, input logic [10:0] hold);
      if (run_open)
         lcd_phases_due.push_back(run_tail);
      run_tail.data = data;
      run_tail.rs   = rs;
      run_tail.e    = e;
      run_tail.hold = hold;
      run_tail.last = 1'b0;
      run_open      = 1'b1;
      pin_data      = data;
      pin_rs        = rs;
   endfunction

   // Setup, strobe and release; the release stretches by extra
   function automatic void emit_write(input logic [7:0] data, input logic rs,
                                      input logic [10:0] extra);
      emit_phase(data, rs, 1'b0, HOLD_SETUP);
      emit_phase(data, rs, 1'b1, HOLD_STROBE);
      emit_phase(data, rs, 1'b0, HOLD_RELEASE + extra);
   endfunction

   function automatic void predict_bus_run(input logic [2:0] kind, input logic [31:0] value,
                                           input logic [1:0] line, input logic [3:0] col);
      logic [3:0]  digits [MAX_DIGITS];
      logic [31:0] rest;
      int          ccol;
      int          n;
      ccol = int'(col);
      if (ccol > COLUMNS - 1)
         ccol = COLUMNS - 1;
      case (kind)
         KIND_INIT: begin
            emit_phase(8'h00, 1'b0, 1'b0, HOLD_POWER_UP);
            emit_write(CMD_WAKE, 1'b0, EXTRA_WAKE1);
            emit_write(CMD_WAKE, 1'b0, EXTRA_WAKE2);
            emit_write(CMD_WAKE, 1'b0, EXTRA_WAKE2);
            emit_write(CMD_FUNC_SET, 1'b0, EXTRA_NONE);
            emit_write(CMD_CURSOR_OFF, 1'b0, EXTRA_NONE);
            emit_write(CMD_DISPLAY_ON, 1'b0, EXTRA_NONE);
            emit_write(CMD_ENTRY_MODE, 1'b0, EXTRA_NONE);
         end
         KIND_COMMAND: emit_write(value[7:0], 1'b0, EXTRA_NONE);
         KIND_CHAR:    emit_write(value[7:0], 1'b1, EXTRA_NONE);
         KIND_CLEAR:   emit_write(CMD_CLEAR, 1'b0, HOLD_LONG);
         KIND_CURSOR: begin
            if (line == LINE_ONE) begin
               // home, then walk right; only the final release carries the long wait
               emit_write(CMD_HOME, 1'b0, (ccol == 0) ? HOLD_LONG : EXTRA_NONE);
               for (int i = 0; i < ccol; i++)
                  emit_write(CMD_SHIFT_R, 1'b0, (i + 1 == ccol) ? HOLD_LONG : EXTRA_NONE);
            end else if (line == LINE_TWO) begin
               emit_write(CMD_LINE_TWO + 8'(ccol), 1'b0, HOLD_LONG);
            end else begin
               // no move: a single long wait with whatever the pins last showed
               emit_phase(pin_data, pin_rs, 1'b0, HOLD_LONG);
            end
         end
         KIND_PRINT: begin
            // split into digits, least significant first, then send them back to front
            rest = value;
            n    = 0;
            do begin
               digits[n] = 4'(rest % 10);
               rest      = rest / 10;
               n++;
            end while (rest != 0 && n < MAX_DIGITS);
            while (n > 0) begin
               n--;
               emit_write(ASCII_ZERO + {4'h0, digits[n]}, 1'b1, EXTRA_NONE);
            end
         end
         default: return;
      endcase
      if (run_open) begin
         run_tail.last = 1'b1;
         lcd_phases_due.push_back(run_tail);
         run_open = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // Shared helpers
   // ------------------------------------------------------------------

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : int'($urandom_range(12, 0));
   endfunction

   function automatic void note_fault(input string what);
      fault_count++;
      if (fault_count <= 10)
         $display("%s", what);
   endfunction

   // Offer one request and wait for it to be taken. Valid is left high on
   // return so that a back-to-back request never drops and re-raises it in
   // one time step; a gap or drop_request lowers it.
   task automatic send_request(input logic [2:0] kind, input logic [31:0] value,
                               input logic [1:0] line, input logic [3:0] col);
      int gap;
      gap = draw_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      req_line  <= line;
      req_col   <= col;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_bus_run(kind, value, line, col);
   endtask

   task automatic drop_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // The idle-line wait straight after reset must show the reset pin levels
   task automatic test_pins_after_reset();
      send_request(KIND_CURSOR, $urandom, LINE_IDLE_LO, 4'($urandom));
   endtask

   task automatic test_power_up();
      send_request(KIND_INIT, $urandom, 2'($urandom), 4'($urandom));
   endtask

   // Byte extremes, with the ignored upper bits of value set against them
   task automatic test_byte_writes();
      send_request(KIND_COMMAND, 32'hFFFF_FF00, 2'($urandom), 4'($urandom));
      send_request(KIND_COMMAND, 32'h0000_00FF, 2'($urandom), 4'($urandom));
      send_request(KIND_CHAR,    32'h0000_00FF, 2'($urandom), 4'($urandom));
      send_request(KIND_CHAR,    32'hFFFF_FF00, 2'($urandom), 4'($urandom));
      send_request(KIND_CLEAR,   $urandom,      2'($urandom), 4'($urandom));
   endtask

   task automatic test_cursor_moves();
      send_request(KIND_CURSOR, $urandom, LINE_ONE, 4'd0);
      send_request(KIND_CURSOR, $urandom, LINE_ONE, 4'd15);
      send_request(KIND_CURSOR, $urandom, LINE_TWO, 4'd0);
      send_request(KIND_CURSOR, $urandom, LINE_TWO, 4'd15);
      // leave RS high, then make sure the idle-line wait holds it
      send_request(KIND_CHAR,   32'h0000_00A7, 2'($urandom), 4'($urandom));
      send_request(KIND_CURSOR, $urandom, LINE_IDLE_HI, 4'd9);
   endtask

   // Zero, single digit, first carry, full width and a run of inner zeros
   task automatic test_decimal_print();
      send_request(KIND_PRINT, 32'd0,          2'($urandom), 4'($urandom));
      send_request(KIND_PRINT, 32'd9,          2'($urandom), 4'($urandom));
      send_request(KIND_PRINT, 32'd10,         2'($urandom), 4'($urandom));
      send_request(KIND_PRINT, 32'hFFFF_FFFF,  2'($urandom), 4'($urandom));
      send_request(KIND_PRINT, 32'd1000000000, 2'($urandom), 4'($urandom));
   endtask

   // Spare kinds: nothing comes out and the held pins survive them
   task automatic test_spare_kinds();
      send_request(KIND_CHAR,     32'h0000_0041, 2'($urandom), 4'($urandom));
      send_request(KIND_SPARE_LO, $urandom,      2'($urandom), 4'($urandom));
      send_request(KIND_SPARE_HI, $urandom,      2'($urandom), 4'($urandom));
      send_request(KIND_CURSOR,   $urandom,      LINE_IDLE_LO, 4'($urandom));
   endtask

   // Hold the result side off for a long stretch while requests keep coming,
   // so the block sits mid-run and has to stall its request side
   task automatic test_backpressure();
      sender_calm   = 1'b1;
      sink_hold_req = HOLD_OFF;
      repeat (6) begin
         send_request(KIND_PRINT, $urandom, 2'($urandom), 4'($urandom));
         send_request(KIND_CHAR,  $urandom, 2'($urandom), 4'($urandom));
      end
      sender_calm = 1'b0;
   endtask

   task automatic test_random_traffic();
      int          sent;
      int          pick;
      logic [2:0]  kind;
      logic [31:0] value;
      logic [1:0]  line;
      logic [3:0]  col;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // re-draw the idling mood now and then so both quiet and busy stretches occur
         if ($urandom_range(19, 0) == 0) begin
            sender_calm = ($urandom_range(3, 0) == 0);
            sink_calm   = ($urandom_range(3, 0) == 0);
         end
         value = $urandom;
         line  = 2'($urandom);
         // keep most cursor walks short; a full-width walk is 48 phases
         col   = 4'($urandom_range(3, 0));
         if ($urandom_range(7, 0) == 0)
            col = 4'($urandom);
         pick = $urandom_range(99, 0);
         if (pick < 3)
            kind = KIND_INIT;
         else if (pick < 25)
            kind = KIND_COMMAND;
         else if (pick < 50)
            kind = KIND_CHAR;
         else if (pick < 57)
            kind = KIND_CLEAR;
         else if (pick < 75)
            kind = KIND_CURSOR;
         else if (pick < 95)
            kind = KIND_PRINT;
         else
            kind = ($urandom_range(1, 0) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
         // spread the number of printed digits
         if (kind == KIND_PRINT) begin
            case ($urandom_range(3, 0))
               0: value = $urandom_range(9, 0);
               1: value = $urandom_range(99999, 0);
               2: value = 32'hFFFF_FFFF - $urandom_range(999, 0);
               default: ;
            endcase
         end
         send_request(kind, value, line, col);
         if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI)
            sent++;
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: stall at random, check every accepted phase in order
   // ------------------------------------------------------------------

   initial begin : phase_sink
      int            sink_wait;
      lcd_phase_type seen;
      lcd_phase_type want;
      sink_wait = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen.data = rsp_data_bus;
            seen.rs   = rsp_reg_select;
            seen.e    = rsp_enable;
            seen.hold = rsp_hold_time;
            seen.last = rsp_last;
            if (lcd_phases_due.size() == 0) begin
               note_fault($sformatf("unexpected bus phase: data=%h rs=%b e=%b hold=%0d last=%b",
                                    seen.data, seen.rs, seen.e, seen.hold, seen.last));
            end else begin
               want = lcd_phases_due.pop_front();
               if (seen.data !== want.data || seen.rs !== want.rs || seen.e !== want.e ||
                   seen.hold !== want.hold || seen.last !== want.last)
                  note_fault($sformatf({"bus phase mismatch: expected data=%h rs=%b e=%b ",
                                        "hold=%0d last=%b, got data=%h rs=%b e=%b hold=%0d ",
                                        "last=%b"},
                                       want.data, want.rs, want.e, want.hold, want.last,
                                       seen.data, seen.rs, seen.e, seen.hold, seen.last));
            end
            sink_wait = draw_gap(sink_calm);
         end
         // a requested hold-off overrides the per-transaction wait
         if (sink_hold_req != 0) begin
            sink_wait     = sink_hold_req;
            sink_hold_req = 0;
         end
         if (sink_wait > 0) begin
            rsp_stall <= 1'b1;
            sink_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: abandon the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_ticks <= 0;
      end else if (idle_ticks + 1 >= IDLE_LIMIT) begin
         $display("[char_lcd_bus_sequencer] ERROR");
         $finish;
      end else begin
         idle_ticks <= idle_ticks + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_kind  <= KIND_INIT;
      req_value <= '0;
      req_line  <= '0;
      req_col   <= '0;
      pin_data  = '0;
      pin_rs    = 1'b0;
      run_open  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_pins_after_reset();
      test_power_up();
      test_byte_writes();
      test_cursor_moves();
      test_decimal_print();
      test_spare_kinds();
      test_backpressure();
      test_random_traffic();

      // drain: wait for every owed phase, then watch a while for strays
      drop_request();
      while (lcd_phases_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      if (fault_count == 0)
         $display("[char_lcd_bus_sequencer] OK");
      else
         $display("[char_lcd_bus_sequencer] ERROR");
      $finish;
   end

endmodule
